// ===== design/isl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types for the indexed shift list: command and error codes,
// and the control word broadcast to the cell row. No dependencies.
package isl_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_READ    = 3'd3,
        CMD_WRITE   = 3'd4,
        CMD_RESERVE = 3'd5,
        CMD_CLEAR   = 3'd6
    } isl_cmd_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_FULL  = 2'd3
    } isl_err_t;

    // Control broadcast to every cell at once.
    typedef struct packed {
        logic shift;   // close a gap: cells at or above the position take their neighbor
        logic write;   // load the write word at the write position
    } isl_cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/isl_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Request channel of the indexed shift list: valid/ready plus one command.
// Depends on isl_pkg.
interface isl_cmd_if;
    logic              valid;
    logic              ready;
    isl_pkg::isl_cmd_t command;
    logic [5:0]        index;
    logic signed [31:0] value;
    logic [6:0]        requested_capacity;

    modport source (output valid, command, index, value, requested_capacity, input ready);
    modport sink   (input valid, command, index, value, requested_capacity, output ready);
endinterface
`default_nettype wire

// ===== design/isl_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the indexed shift list: valid/ready plus list status.
// Depends on isl_pkg.
interface isl_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    isl_pkg::isl_err_t  error_code;
    logic [6:0]         element_count;
    logic [6:0]         capacity_now;
    logic               is_empty;

    modport source (output valid, read_value, error_code, element_count, capacity_now,
                    is_empty, input ready);
    modport sink   (input valid, read_value, error_code, element_count, capacity_now,
                    is_empty, output ready);
endinterface
`default_nettype wire

// ===== design/indexed_shift_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Indexed shift list: top level with count/capacity control and the cell row.
// Depends on isl_pkg, isl_cmd_if, isl_rsp_if and isl_cell.
//
// A growable list of up to DEPTH signed 32-bit words. Each request carries one
// command (push, pop, remove at index, read, write, reserve, clear) and gets
// exactly one response with the word read (zero unless a pop or read succeeds),
// an error code, the element count, the tracked capacity and an empty flag.
// Each command completes at its accepting edge: the cell row and the counters
// update there, and the response is loaded into the output register, visible
// in the following cycle. A new request is taken each cycle while the
// response register is empty or being drained, so throughput is one command
// per clock. Removal closes the gap in the same cycle because every cell at or
// above the index loads its right neighbor at once. Reads and pops select a
// word by matching the position in each cell and OR-combining the row. Storage
// needs no clearing pass after reset: positions below the count are always
// written before they are read, so clear just zeroes count and capacity.
module indexed_shift_list #(
    parameter int DEPTH = 64
) (
    input wire logic  clk,
    input wire logic  rst_n,
    isl_cmd_if.sink   cmd,
    isl_rsp_if.source rsp
);
    import isl_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0]   DEPTH_C  = CW'(DEPTH);
    localparam logic [CMPW-1:0] DEPTH_W  = CMPW'(DEPTH);
    localparam logic [CW:0]     DEPTH_X  = (CW + 1)'(DEPTH);

    // List state
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cap_reg, cap_next;

    // Response register
    logic        rsp_valid_reg;
    logic [31:0] rd_value_reg, rd_value_next;
    isl_err_t    err_reg, err_next;

    // Cell row control
    isl_cell_ctl_t ctl;
    logic [AW-1:0] shift_pos, wr_pos, rd_pos;
    logic [31:0]   row_data [DEPTH];
    logic [31:0]   row_rd   [DEPTH];
    logic [31:0]   rd_any;

    logic            accept;
    logic [CMPW-1:0] idx_w, cnt_w, req_w, cap_w;
    logic            in_range;
    logic [CW-1:0]   count_dec;
    logic [CW:0]     cap_dbl;

    // Accept a request whenever the response slot is free or draining.
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign idx_w     = CMPW'(cmd.index);
    assign cnt_w     = CMPW'(count_reg);
    assign req_w     = CMPW'(cmd.requested_capacity);
    assign cap_w     = CMPW'(cap_reg);
    assign in_range  = idx_w < cnt_w;
    assign count_dec = count_reg - CW'(1);
    assign cap_dbl   = {cap_reg, 1'b0};

    // Position buses: pop reads the last word, push writes just past it.
    assign shift_pos = idx_w[AW-1:0];
    assign rd_pos    = (cmd.command == CMD_POP) ? AW'(count_dec) : idx_w[AW-1:0];
    assign wr_pos    = (cmd.command == CMD_WRITE) ? idx_w[AW-1:0] : AW'(count_reg);

    // Combine the row read taps.
    always_comb
    begin
        rd_any = 32'd0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_any = rd_any | row_rd[i];
        end
    end

    // Command decode and next state
    always_comb
    begin
        count_next    = count_reg;
        cap_next      = cap_reg;
        err_next      = ERR_OK;
        rd_value_next = 32'd0;
        ctl           = '0;
        unique case (cmd.command)
            CMD_PUSH:
            begin
                if (count_reg == DEPTH_C)
                begin
                    err_next = ERR_FULL;
                end
                else
                begin
                    if (count_reg >= cap_reg)
                    begin
                        if (cap_reg == '0)
                        begin
                            cap_next = CW'(1);
                        end
                        else if (cap_dbl > DEPTH_X)
                        begin
                            cap_next = DEPTH_C;
                        end
                        else
                        begin
                            cap_next = cap_dbl[CW-1:0];
                        end
                    end
                    ctl.write  = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP:
            begin
                if (count_reg == '0)
                begin
                    err_next = ERR_EMPTY;
                end
                else
                begin
                    rd_value_next = rd_any;
                    count_next    = count_dec;
                    if (count_dec <= (cap_reg >> 1))
                    begin
                        cap_next = cap_reg >> 1;
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (!in_range)
                begin
                    err_next = ERR_RANGE;
                end
                else
                begin
                    ctl.shift  = accept;
                    count_next = count_dec;
                    if (count_dec <= (cap_reg >> 1))
                    begin
                        cap_next = cap_reg >> 1;
                    end
                end
            end
            CMD_READ:
            begin
                if (!in_range)
                begin
                    err_next = ERR_RANGE;
                end
                else
                begin
                    rd_value_next = rd_any;
                end
            end
            CMD_WRITE:
            begin
                if (!in_range)
                begin
                    err_next = ERR_RANGE;
                end
                else
                begin
                    ctl.write = accept;
                end
            end
            CMD_RESERVE:
            begin
                if (req_w > cap_w)
                begin
                    cap_next = (req_w > DEPTH_W) ? DEPTH_C : req_w[CW-1:0];
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
                cap_next   = '0;
            end
            default:
            begin
                // Undefined command: no change, no error.
            end
        endcase
    end

    // List state and the response load only on an accepted request; a drained response drops valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            err_reg       <= ERR_OK;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                cap_reg       <= cap_next;
                err_reg       <= err_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_value_reg <= rd_value_next;
        end
    end

    // Cell row: each cell hands its word to the left neighbor on a gap close.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [31:0] right_word;
        if (g == DEPTH - 1)
        begin : g_last
            assign right_word = row_data[g];
        end
        else
        begin : g_mid
            assign right_word = row_data[g + 1];
        end

        isl_cell #(
            .AW  (AW),
            .POS (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .shift_pos  (shift_pos),
            .wr_pos     (wr_pos),
            .wr_data    (cmd.value),
            .rd_pos     (rd_pos),
            .right_data (right_word),
            .data       (row_data[g]),
            .rd_data    (row_rd[g])
        );
    end

    // Response fields: status reflects the state left by the last request,
    // which cannot change while the response waits.
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_value    = rd_value_reg;
    assign rsp.error_code    = err_reg;
    assign rsp.element_count = 7'(count_reg);
    assign rsp.capacity_now  = 7'(cap_reg);
    assign rsp.is_empty      = (count_reg == '0);

    // Assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("element count above depth");

    a_cap_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg >= count_reg)
        else $error("capacity below element count");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.command == CMD_PUSH && count_reg != DEPTH_C)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow the list");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |-> !cmd.ready)
        else $error("request taken while response stalled");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(count_reg) && $stable(cap_reg)))
        else $error("list state changed without a request");

endmodule
`default_nettype wire

// ===== design/isl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One storage cell of the list: holds a word, takes its right neighbor
// on a gap close, loads on a write hit. Depends on isl_pkg.
module isl_cell #(
    parameter int AW  = 6,
    parameter int POS = 0
) (
    input  wire logic                   clk,
    input  wire isl_pkg::isl_cell_ctl_t ctl,
    input  wire logic [AW-1:0]          shift_pos,
    input  wire logic [AW-1:0]          wr_pos,
    input  wire logic [31:0]            wr_data,
    input  wire logic [AW-1:0]          rd_pos,
    input  wire logic [31:0]            right_data,
    output logic      [31:0]            data,
    output logic      [31:0]            rd_data
);
    import isl_pkg::*;

    localparam logic [AW-1:0] MY_POS = AW'(POS);

    logic [31:0] word_reg;

    // Shift takes priority; the two never meet in the same cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.shift && (MY_POS >= shift_pos))
        begin
            word_reg <= right_data;
        end
        else if (ctl.write && (MY_POS == wr_pos))
        begin
            word_reg <= wr_data;
        end
    end

    assign data    = word_reg;
    assign rd_data = (rd_pos == MY_POS) ? word_reg : 32'd0;

endmodule
`default_nettype wire
